// ===== src/greedy_change_dispenser_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the change dispenser
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef GREEDY_CHANGE_DISPENSER_DEFINES_SVH
`define GREEDY_CHANGE_DISPENSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GCHG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GCHG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gchg_pkg.sv =====
// ----------------------------------------------------------------------------
// gchg_pkg
// Widths, types and codes shared by the change dispenser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gchg_pkg;

  localparam int unsigned NUM_SLOTS   = 5;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned DENOM_W     = 10;
  localparam int unsigned AMOUNT_W    = 16;
  localparam int unsigned CNT_IN_W    = 10;
  localparam int unsigned CNT_OUT_W   = 10;
  localparam int unsigned COUNT_WIDTH = 10;
  localparam int unsigned BIT_W       = $clog2(COUNT_WIDTH);
  localparam int unsigned PROD_W      = DENOM_W + COUNT_WIDTH;
  // five products summed: three extra bits
  localparam int unsigned TOTAL_W     = PROD_W + 3;
  localparam int unsigned TRIAL_W     = (PROD_W > AMOUNT_W) ? PROD_W : AMOUNT_W;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = DENOM_W;

  typedef logic [DENOM_W-1:0]     denom_t;
  typedef logic [AMOUNT_W-1:0]    amount_t;
  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [CNT_IN_W-1:0]    cnt_in_t;
  typedef logic [CNT_OUT_W-1:0]   cnt_out_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [TOTAL_W-1:0]     total_t;

  localparam denom_t DENOM_RST [NUM_SLOTS] = '{10'd50, 10'd25, 10'd10, 10'd5, 10'd1};

  localparam logic FUNC_WITHDRAW = 1'b0;
  localparam logic FUNC_STOCK    = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_NOCHANGE = 2'd2,
    ST_ZERO     = 2'd3
  } gchg_status_e;

  // Data handed from one cell to the next.
  typedef struct packed {
    logic    sum_vld;
    total_t  sum;
    logic    div_vld;
    amount_t rest;
  } gchg_link_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic    stock_we;
    cnt_in_t stock_val;
    logic    commit;
  } gchg_cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/gchg_in_if.sv =====
// ----------------------------------------------------------------------------
// gchg_in_if
// Request channel: withdraw or stock item with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gchg_in_if;
  import gchg_pkg::*;

  logic    valid;
  logic    ready;
  logic    func;
  amount_t amount;
  slot_t   slot;
  cnt_in_t stock_count;

  modport source (output valid, output func, output amount, output slot,
                  output stock_count, input ready);
  modport sink   (input valid, input func, input amount, input slot,
                  input stock_count, output ready);
endinterface

`default_nettype wire

// ===== src/gchg_out_if.sv =====
// ----------------------------------------------------------------------------
// gchg_out_if
// Result channel: status and per-slot payout with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gchg_out_if;
  import gchg_pkg::*;

  logic         valid;
  logic         ready;
  gchg_status_e status;
  cnt_out_t     count_slot0;
  cnt_out_t     count_slot1;
  cnt_out_t     count_slot2;
  cnt_out_t     count_slot3;
  cnt_out_t     count_slot4;

  modport source (output valid, output status, output count_slot0, output count_slot1,
                  output count_slot2, output count_slot3, output count_slot4,
                  input ready);
  modport sink   (input valid, input status, input count_slot0, input count_slot1,
                  input count_slot2, input count_slot3, input count_slot4,
                  output ready);
endinterface

`default_nettype wire

// ===== src/gchg_cell.sv =====
// ----------------------------------------------------------------------------
// gchg_cell
// One slot of the chain: holds stock, adds its value to the passing total
// and works out its coin take bit by bit before handing the rest on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gchg_cell (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire gchg_pkg::denom_t        denom_i,
  input  wire gchg_pkg::gchg_cell_ctl_t ctl_i,
  input  wire gchg_pkg::gchg_link_t    link_i,
  output gchg_pkg::gchg_link_t         link_o,
  output gchg_pkg::count_t             take_o
);
  import gchg_pkg::*;

  count_t              stock_q;
  count_t              take_q;
  amount_t             rem_q;
  logic [BIT_W-1:0]    bit_q;
  logic                busy_q;
  gchg_link_t          link_q;

  count_t              trial_cnt;
  logic [TRIAL_W-1:0]  trial_val;
  logic [TRIAL_W-1:0]  rem_ext;
  logic                fit;
  logic                last;
  amount_t             rem_step;
  logic [PROD_W-1:0]   prod;

  // Try one quotient bit: keep it if it stays within stock and within the rest.
  assign trial_cnt = take_q | (count_t'(1) << bit_q);
  assign trial_val = TRIAL_W'(denom_i) << bit_q;
  assign rem_ext   = TRIAL_W'(rem_q);
  assign fit       = (denom_i != '0) && (trial_cnt <= stock_q) && (rem_ext >= trial_val);
  assign rem_step  = fit ? AMOUNT_W'(rem_ext - trial_val) : rem_q;
  assign last      = (bit_q == '0);
  assign prod      = PROD_W'(denom_i) * PROD_W'(stock_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stock_q <= '0;
      take_q  <= '0;
      rem_q   <= '0;
      bit_q   <= '0;
      busy_q  <= 1'b0;
      link_q  <= '0;
    end else begin
      if (link_i.div_vld) begin
        busy_q <= 1'b1;
        bit_q  <= BIT_W'(COUNT_WIDTH - 1);
        take_q <= '0;
        rem_q  <= link_i.rest;
      end else if (busy_q) begin
        if (fit) begin
          take_q <= trial_cnt;
        end
        rem_q <= rem_step;
        bit_q <= bit_q - BIT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end

      link_q.sum_vld <= link_i.sum_vld;
      link_q.sum     <= link_i.sum + TOTAL_W'(prod);
      link_q.div_vld <= busy_q && last;
      link_q.rest    <= rem_step;

      if (ctl_i.stock_we) begin
        stock_q <= COUNT_WIDTH'(ctl_i.stock_val);
      end else if (ctl_i.commit) begin
        stock_q <= stock_q - take_q;
      end
    end
  end

  assign link_o = link_q;
  assign take_o = take_q;

endmodule

`default_nettype wire

// ===== src/greedy_change_dispenser.sv =====
// Withdraw item: from accept, the stock total ripples down the five cells through
// their link registers, then each cell in turn works out its bit-serial coin take
// and hands the rest on, then the result passes the response state into the output
// registers. Stock items and zero amounts go straight to the response state. One
// item is in work at a time. Reset (async, active low) clears all stock to zero and
// loads the denominations 50, 25, 10, 5, 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
// greedy_change_dispenser
// Five-slot coin stock with greedy, stock-limited change making.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "greedy_change_dispenser_defines.svh"

module greedy_change_dispenser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [gchg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [gchg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  gchg_in_if.sink                            in_i,
  gchg_out_if.source                         out_o
);
  import gchg_pkg::*;

  // One-hot sequencer: accept, total the stock, make change, deliver.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SUM  = 4'b0010,
    S_DIV  = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e         state_q, state_d;
  gchg_status_e   status_q, status_d;
  logic           pay_q, pay_d;
  amount_t        amount_q;
  denom_t         denom_q [NUM_SLOTS];

  logic           out_valid_q;
  gchg_status_e   out_status_q;
  cnt_out_t       out_cnt_q [NUM_SLOTS];

  gchg_link_t     link_w [NUM_SLOTS+1];
  gchg_cell_ctl_t ctl_w  [NUM_SLOTS];
  count_t         take_w [NUM_SLOTS];
  gchg_link_t     tail;

  logic           accept;
  logic           is_stock;
  logic           short_total;
  logic           exact;
  logic           commit;
  logic           out_load;

  assign accept      = in_i.valid && in_i.ready;
  assign is_stock    = (in_i.func == FUNC_STOCK);
  assign tail        = link_w[NUM_SLOTS];
  assign short_total = TOTAL_W'(amount_q) > tail.sum;
  assign exact       = (tail.rest == '0);
  assign commit      = (state_q == S_DIV) && tail.div_vld && exact;
  assign out_load    = (state_q == S_RESP) && (!out_valid_q || out_o.ready);

  // Take a new beat only when idle; a waiting result sits in the output register.
  assign in_i.ready = (state_q == S_IDLE);

  // Head of the chain: start the running total at accept, start change making
  // once the total covers the amount.
  assign link_w[0].sum_vld = accept && !is_stock && (in_i.amount != '0);
  assign link_w[0].sum     = '0;
  assign link_w[0].div_vld = (state_q == S_SUM) && tail.sum_vld && !short_total;
  assign link_w[0].rest    = amount_q;

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_slot
    // Stock writes to slots beyond the last one match no cell and drop.
    assign ctl_w[k].stock_we  = accept && is_stock && (in_i.slot == SLOT_W'(k));
    assign ctl_w[k].stock_val = in_i.stock_count;
    assign ctl_w[k].commit    = commit;

    gchg_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .denom_i (denom_q[k]),
      .ctl_i   (ctl_w[k]),
      .link_i  (link_w[k]),
      .link_o  (link_w[k+1]),
      .take_o  (take_w[k])
    );

    // Denomination register; writes beyond the last index drop.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        denom_q[k] <= DENOM_RST[k];
      end else if (cfg_we_i && (cfg_idx_i == CFG_IDX_W'(k))) begin
        denom_q[k] <= cfg_data_i;
      end
    end

    // Result counts: payout only for a successful withdraw, else zero.
    always_ff @(posedge clk_i) begin
      if (out_load) begin
        out_cnt_q[k] <= pay_q ? CNT_OUT_W'(take_w[k]) : '0;
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    pay_d    = pay_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          pay_d = 1'b0;
          if (is_stock) begin
            status_d = ST_OK;
            state_d  = S_RESP;
          end else if (in_i.amount == '0) begin
            status_d = ST_ZERO;
            state_d  = S_RESP;
          end else begin
            state_d  = S_SUM;
          end
        end
      end
      S_SUM: begin
        if (tail.sum_vld) begin
          if (short_total) begin
            status_d = ST_SHORT;
            state_d  = S_RESP;
          end else begin
            state_d  = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (tail.div_vld) begin
          status_d = exact ? ST_OK : ST_NOCHANGE;
          pay_d    = exact;
          state_d  = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= ST_OK;
      pay_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      pay_q    <= pay_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the requested amount for the whole withdraw.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      amount_q <= in_i.amount;
    end
    if (out_load) begin
      out_status_q <= status_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.count_slot0 = out_cnt_q[0];
  assign out_o.count_slot1 = out_cnt_q[1];
  assign out_o.count_slot2 = out_cnt_q[2];
  assign out_o.count_slot3 = out_cnt_q[3];
  assign out_o.count_slot4 = out_cnt_q[4];

  `GCHG_ASSERT_NXT(a_one_item, clk_i, rst_ni, accept, !in_i.ready,
                   "new beat taken while an item is in work")
  `GCHG_ASSERT_IMP(a_sum_phase, clk_i, rst_ni, tail.sum_vld, state_q == S_SUM,
                   "stock total arrived outside the total phase")
  `GCHG_ASSERT_IMP(a_div_phase, clk_i, rst_ni, tail.div_vld, state_q == S_DIV,
                   "change result arrived outside the change phase")
  `GCHG_ASSERT_NXT(a_commit_pays, clk_i, rst_ni, commit, pay_q && status_q == ST_OK,
                   "stock committed without a successful payout")
  `GCHG_ASSERT_IMP(a_fail_no_coins, clk_i, rst_ni,
                   out_o.valid && out_o.status != ST_OK,
                   out_o.count_slot0 == '0 && out_o.count_slot1 == '0 &&
                   out_o.count_slot2 == '0 && out_o.count_slot3 == '0 &&
                   out_o.count_slot4 == '0,
                   "coins reported on a failed withdraw")

endmodule

`default_nettype wire
